@@ rtl/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, the reset value and the pipeline tag shared by the face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int CoordW   = 24;
    localparam int EdgeW    = 25;
    localparam int ProdW    = 50;
    localparam int CrossW   = 51;
    localparam int MagW     = 50;
    localparam int UnitMagW = 30;
    localparam int SqW      = 2 * UnitMagW;
    localparam int SumW     = 62;
    localparam int RootW    = SumW / 2;
    localparam int RemW     = RootW + 3;
    localparam int QuoW     = 15;
    localparam int NumW     = RootW + QuoW;
    localparam int FracW    = 14;
    localparam int CompW    = 16;
    localparam int ShiftW   = 5;
    localparam int IdxW     = 32;
    localparam int ThrW     = 15;
    localparam int TProdW   = 32;
    localparam int TqW      = 30;
    localparam int UnitLat  = 3 + RootW + QuoW;

    localparam logic [ThrW-1:0] THRESH_RESET = 15'd14746;

    typedef struct packed {
        logic                    valid;
        logic                    degen;
        logic [IdxW-1:0]         idx_a;
        logic [IdxW-1:0]         idx_b;
        logic [IdxW-1:0]         idx_c;
        logic signed [CompW-1:0] nrm_x;
        logic signed [CompW-1:0] nrm_y;
        logic signed [CompW-1:0] nrm_z;
    } tag_t;

endpackage

@@ rtl/tfn_sqrt.sv @@
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SumW-1:0]  radicand,
    output logic [RootW-1:0] root
);

    logic [SumW-1:0]  x_reg [RootW];
    logic [RemW-1:0]  r_reg [RootW];
    logic [RootW-1:0] q_reg [RootW];

    genvar k;
    generate
        for (k = 0; k < RootW; k++)
        begin : g_stage
            localparam int P = RootW - 1 - k;
            logic [SumW-1:0]  x_in;
            logic [RemW-1:0]  r_in;
            logic [RootW-1:0] q_in;
            logic [RemW-1:0]  r_sh;
            logic [RemW-1:0]  trial;
            logic [RemW-1:0]  r_next;
            logic [RootW-1:0] q_next;

            if (k == 0)
            begin : g_first
                assign x_in = radicand;
                assign r_in = '0;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign x_in = x_reg[k-1];
                assign r_in = r_reg[k-1];
                assign q_in = q_reg[k-1];
            end

            always_comb
            begin
                r_sh  = {r_in[RemW-3:0], x_in[2*P+1 -: 2]};
                trial = {1'b0, q_in, 2'b01};
                if (r_sh >= trial)
                begin
                    r_next = r_sh - trial;
                    q_next = {q_in[RootW-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_sh;
                    q_next = {q_in[RootW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= x_in;
                    r_reg[k] <= r_next;
                    q_reg[k] <= q_next;
                end
            end
        end
    endgenerate

    assign root = q_reg[RootW-1];

endmodule

@@ rtl/tfn_div.sv @@
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider, one quotient bit per stage; zero divisor
// gives zero.
// ----------------------------------------------------------------------------
module tfn_div
    import tfn_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NumW-1:0]  num,
    input  logic [RootW-1:0] den,
    output logic [QuoW-1:0]  quo
);

    logic [NumW-1:0]  rem_reg [QuoW];
    logic [RootW-1:0] den_reg [QuoW];
    logic [QuoW-1:0]  q_reg   [QuoW];

    genvar k;
    generate
        for (k = 0; k < QuoW; k++)
        begin : g_stage
            localparam int J = QuoW - 1 - k;
            logic [NumW-1:0]  rem_in;
            logic [RootW-1:0] den_in;
            logic [QuoW-1:0]  q_in;
            logic [NumW-1:0]  sub;
            logic [NumW-1:0]  rem_next;
            logic [QuoW-1:0]  q_next;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            always_comb
            begin
                sub = NumW'(den_in) << J;
                if (rem_in >= sub)
                begin
                    rem_next = rem_in - sub;
                    q_next   = {q_in[QuoW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_in;
                    q_next   = {q_in[QuoW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    q_reg[k]   <= q_next;
                end
            end
        end
    endgenerate

    assign quo = (den_reg[QuoW-1] == '0) ? '0 : q_reg[QuoW-1];

endmodule

@@ rtl/tfn_unit.sv @@
// ----------------------------------------------------------------------------
// tfn_unit
// Scales a three-component magnitude vector to unit length in Q1.14:
// squares, sum, square root, three dividers, sign.
// ----------------------------------------------------------------------------
module tfn_unit
    import tfn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  tag_t                    tag_in,
    input  logic [UnitMagW-1:0]     mag [3],
    input  logic [2:0]              neg,
    output tag_t                    tag_out,
    output logic signed [CompW-1:0] comp [3]
);

    tag_t                tag1_reg, tag2_reg;
    logic [SqW-1:0]      sq_reg  [3];
    logic [UnitMagW-1:0] m1_reg  [3];
    logic [UnitMagW-1:0] m2_reg  [3];
    logic [2:0]          neg1_reg, neg2_reg;
    logic [SumW-1:0]     sum_reg;

    tag_t                tag_sq_reg [RootW];
    logic [UnitMagW-1:0] m_sq_reg   [RootW][3];
    logic [2:0]          neg_sq_reg [RootW];

    tag_t                tag_dv_reg [QuoW];
    logic [2:0]          neg_dv_reg [QuoW];

    tag_t                tag_out_reg;
    logic signed [CompW-1:0] comp_reg [3];

    logic [RootW-1:0]    root;
    logic [QuoW-1:0]     quo [3];
    logic [NumW-1:0]     num [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag_out_reg <= '0;
            for (int i = 0; i < RootW; i++)
            begin
                tag_sq_reg[i] <= '0;
            end
            for (int i = 0; i < QuoW; i++)
            begin
                tag_dv_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            tag_sq_reg[0] <= tag2_reg;
            for (int i = 1; i < RootW; i++)
            begin
                tag_sq_reg[i] <= tag_sq_reg[i-1];
            end
            tag_dv_reg[0] <= tag_sq_reg[RootW-1];
            for (int i = 1; i < QuoW; i++)
            begin
                tag_dv_reg[i] <= tag_dv_reg[i-1];
            end
            tag_out_reg <= tag_dv_reg[QuoW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]      <= SqW'(mag[k]) * SqW'(mag[k]);
                m1_reg[k]      <= mag[k];
                m2_reg[k]      <= m1_reg[k];
                m_sq_reg[0][k] <= m2_reg[k];
                for (int i = 1; i < RootW; i++)
                begin
                    m_sq_reg[i][k] <= m_sq_reg[i-1][k];
                end
                comp_reg[k] <= neg_dv_reg[QuoW-1][k] ? -CompW'(quo[k]) : CompW'(quo[k]);
            end
            neg1_reg      <= neg;
            neg2_reg      <= neg1_reg;
            sum_reg       <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
            neg_sq_reg[0] <= neg2_reg;
            for (int i = 1; i < RootW; i++)
            begin
                neg_sq_reg[i] <= neg_sq_reg[i-1];
            end
            neg_dv_reg[0] <= neg_sq_reg[RootW-1];
            for (int i = 1; i < QuoW; i++)
            begin
                neg_dv_reg[i] <= neg_dv_reg[i-1];
            end
        end
    end

    tfn_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_div
            assign num[k] = (NumW'(m_sq_reg[RootW-1][k]) << FracW) + NumW'(root >> 1);

            tfn_div u_div (
                .clk (clk),
                .en  (en),
                .num (num[k]),
                .den (root),
                .quo (quo[k])
            );
        end
    endgenerate

    assign tag_out = tag_out_reg;
    assign comp    = comp_reg;

endmodule

@@ rtl/triangle_face_normal_tangent.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_tangent
// Unit face normal, orthogonal unit tangent; one triangle per unstalled cycle.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    index_a..c, a_x..c_z
//   out       out_valid / out_stall  out_index_a..c, normal_*, tangent_*,
//                                    degenerate
//   cfg       cfg_valid / cfg_ready  cfg_data (tangent switch threshold)
//
// One triangle enters per unstalled cycle. Stages: 5 front stages (edges,
// cross products, shift), 49 in each scaling unit (31 square root stages
// and 15 divider stages dominate) and 2 for the tangent seed.
// Reset clears all valid bits and loads the threshold with 0.9 in Q1.14.
// A stalled output word holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module triangle_face_normal_tangent
    import tfn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [IdxW-1:0]          index_a,
    input  logic [IdxW-1:0]          index_b,
    input  logic [IdxW-1:0]          index_c,
    input  logic signed [CoordW-1:0] a_x,
    input  logic signed [CoordW-1:0] a_y,
    input  logic signed [CoordW-1:0] a_z,
    input  logic signed [CoordW-1:0] b_x,
    input  logic signed [CoordW-1:0] b_y,
    input  logic signed [CoordW-1:0] b_z,
    input  logic signed [CoordW-1:0] c_x,
    input  logic signed [CoordW-1:0] c_y,
    input  logic signed [CoordW-1:0] c_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [IdxW-1:0]          out_index_a,
    output logic [IdxW-1:0]          out_index_b,
    output logic [IdxW-1:0]          out_index_c,
    output logic signed [CompW-1:0]  normal_x,
    output logic signed [CompW-1:0]  normal_y,
    output logic signed [CompW-1:0]  normal_z,
    output logic signed [CompW-1:0]  tangent_x,
    output logic signed [CompW-1:0]  tangent_y,
    output logic signed [CompW-1:0]  tangent_z,
    output logic                     degenerate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ThrW-1:0]          cfg_data
);

    logic                     en;
    logic [ThrW-1:0]          thr_reg;

    tag_t                     tag_in;
    tag_t                     tag3_next;
    tag_t                     tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic signed [EdgeW-1:0]  e1_reg [3];
    logic signed [EdgeW-1:0]  e2_reg [3];
    logic signed [ProdW-1:0]  p_reg  [6];
    logic signed [CrossW-1:0] cr     [3];
    logic [MagW-1:0]          mag3_reg [3];
    logic [MagW-1:0]          mag4_reg [3];
    logic [2:0]               neg3_reg, neg4_reg, neg5_reg;
    logic [MagW-1:0]          mag_or;
    logic [ShiftW-1:0]        sh_next, sh_reg;
    logic [UnitMagW-1:0]      m5_reg [3];

    tag_t                     ntag;
    logic signed [CompW-1:0]  nrm [3];
    tag_t                     ntag_fill;
    tag_t                     t1_tag_reg, t2_tag_reg;
    logic [CompW-1:0]         nx_mag;
    logic                     sel_next, sel_reg;
    logic signed [CompW-1:0]  d;
    logic signed [TProdW-1:0] tp_reg [3];
    logic signed [TqW-1:0]    tq [3];
    logic [UnitMagW-1:0]      tm_reg [3];
    logic [2:0]               tneg_reg;

    tag_t                     otag;
    logic signed [CompW-1:0]  tan [3];

    assign en        = !(otag.valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_comb
    begin
        tag_in       = '0;
        tag_in.valid = in_valid;
        tag_in.idx_a = index_a;
        tag_in.idx_b = index_b;
        tag_in.idx_c = index_c;
    end

    // cross product and magnitude split
    always_comb
    begin
        cr[0] = CrossW'(p_reg[0]) - CrossW'(p_reg[1]);
        cr[1] = CrossW'(p_reg[2]) - CrossW'(p_reg[3]);
        cr[2] = CrossW'(p_reg[4]) - CrossW'(p_reg[5]);
    end

    always_comb
    begin
        tag3_next       = tag2_reg;
        tag3_next.degen = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    end

    // shift so that the largest magnitude stays below 2^30
    always_comb
    begin
        mag_or  = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        sh_next = '0;
        for (int k = UnitMagW; k < MagW; k++)
        begin
            if (mag_or[k])
            begin
                sh_next = ShiftW'(k - (UnitMagW - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            tag3_reg   <= '0;
            tag4_reg   <= '0;
            tag5_reg   <= '0;
            t1_tag_reg <= '0;
            t2_tag_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg       <= tag_in;
            tag2_reg       <= tag1_reg;
            tag3_reg       <= tag3_next;
            tag4_reg       <= tag3_reg;
            tag5_reg       <= tag4_reg;
            t1_tag_reg     <= ntag_fill;
            t2_tag_reg     <= t1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= EdgeW'(b_x) - EdgeW'(a_x);
            e1_reg[1] <= EdgeW'(b_y) - EdgeW'(a_y);
            e1_reg[2] <= EdgeW'(b_z) - EdgeW'(a_z);
            e2_reg[0] <= EdgeW'(c_x) - EdgeW'(a_x);
            e2_reg[1] <= EdgeW'(c_y) - EdgeW'(a_y);
            e2_reg[2] <= EdgeW'(c_z) - EdgeW'(a_z);

            p_reg[0] <= ProdW'(e1_reg[1]) * ProdW'(e2_reg[2]);
            p_reg[1] <= ProdW'(e1_reg[2]) * ProdW'(e2_reg[1]);
            p_reg[2] <= ProdW'(e1_reg[2]) * ProdW'(e2_reg[0]);
            p_reg[3] <= ProdW'(e1_reg[0]) * ProdW'(e2_reg[2]);
            p_reg[4] <= ProdW'(e1_reg[0]) * ProdW'(e2_reg[1]);
            p_reg[5] <= ProdW'(e1_reg[1]) * ProdW'(e2_reg[0]);

            for (int k = 0; k < 3; k++)
            begin
                mag3_reg[k] <= cr[k][CrossW-1] ? MagW'(-cr[k]) : MagW'(cr[k]);
                neg3_reg[k] <= cr[k][CrossW-1];
                mag4_reg[k] <= mag3_reg[k];
                m5_reg[k]   <= UnitMagW'(mag4_reg[k] >> sh_reg);
            end
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            sh_reg   <= sh_next;

            sel_reg <= sel_next;
            for (int k = 0; k < 3; k++)
            begin
                tp_reg[k] <= TProdW'(nrm[k]) * TProdW'(d);
                tm_reg[k] <= tq[k][TqW-1] ? UnitMagW'(-tq[k]) : UnitMagW'(tq[k]);
                tneg_reg[k] <= tq[k][TqW-1];
            end
        end
    end

    tfn_unit u_normal (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (tag5_reg),
        .mag     (m5_reg),
        .neg     (neg5_reg),
        .tag_out (ntag),
        .comp    (nrm)
    );

    // tangent seed and one Gram-Schmidt step
    always_comb
    begin
        ntag_fill       = ntag;
        ntag_fill.nrm_x = nrm[0];
        ntag_fill.nrm_y = nrm[1];
        ntag_fill.nrm_z = nrm[2];
        nx_mag   = nrm[0][CompW-1] ? -nrm[0] : nrm[0];
        sel_next = nx_mag > CompW'(thr_reg);
        d        = sel_next ? nrm[1] : nrm[0];
    end

    always_comb
    begin
        tq[0] = sel_reg ? -TqW'(tp_reg[0]) : (TqW'(1) << (2 * FracW)) - TqW'(tp_reg[0]);
        tq[1] = sel_reg ? (TqW'(1) << (2 * FracW)) - TqW'(tp_reg[1]) : -TqW'(tp_reg[1]);
        tq[2] = -TqW'(tp_reg[2]);
    end

    tfn_unit u_tangent (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (t2_tag_reg),
        .mag     (tm_reg),
        .neg     (tneg_reg),
        .tag_out (otag),
        .comp    (tan)
    );

    assign out_valid   = otag.valid;
    assign out_index_a = otag.idx_a;
    assign out_index_b = otag.idx_b;
    assign out_index_c = otag.idx_c;
    assign normal_x    = otag.nrm_x;
    assign normal_y    = otag.nrm_y;
    assign normal_z    = otag.nrm_z;
    assign tangent_x   = tan[0];
    assign tangent_y   = tan[1];
    assign tangent_z   = tan[2];
    assign degenerate  = otag.degen;

endmodule

@@ sim/tb_triangle_face_normal_tangent.sv @@
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_tangent
// Self-checking bench for the triangle face normal and tangent unit.
// Triangles go in over the valid/stall channel. A scoreboard predicts the
// unit normal, the tangent and the degenerate flag of each accepted word. It
// checks every output word against the oldest prediction. The run goes
// through several switch thresholds and several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_tangent;
    timeunit 1ns;
    timeprecision 1ps;

    import tfn_pkg::*;

    typedef struct {
        logic [IdxW-1:0]          idx [3];
        logic signed [CoordW-1:0] p   [9];
    } tri_word_t;

    typedef struct {
        logic [IdxW-1:0]         idx [3];
        logic signed [CompW-1:0] nrm [3];
        logic signed [CompW-1:0] tan [3];
        logic                    degen;
    } face_word_t;

    class face_scoreboard;
        face_word_t      pending[$];
        logic [ThrW-1:0] threshold;
        int              errors;
        int              checked;
        int              degen_seen;
        int              yseed_seen;

        function new();
            threshold  = THRESH_RESET;
            errors     = 0;
            checked    = 0;
            degen_seen = 0;
            yseed_seen = 0;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void to_unit(input longint v[3], output longint q[3]);
            longint unsigned m [3];
            longint unsigned len;
            longint unsigned u;
            for (int k = 0; k < 3; k++)
                m[k] = (v[k] < 0) ? -v[k] : v[k];
            len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int k = 0; k < 3; k++)
            begin
                u = 0;
                if (len != 0)
                    u = (m[k] * 16384 + (len >> 1)) / len;
                q[k] = (v[k] < 0) ? -longint'(u) : longint'(u);
            end
        endfunction

        function void note(tri_word_t w);
            longint          p  [9];
            longint          e1 [3];
            longint          e2 [3];
            longint          cr [3];
            longint          nv [3];
            longint          tq [3];
            longint          tv [3];
            longint unsigned big;
            longint unsigned mg;
            longint          d;
            int              sh;
            face_word_t      r;
            for (int k = 0; k < 9; k++)
                p[k] = w.p[k];
            for (int k = 0; k < 3; k++)
            begin
                e1[k] = p[3 + k] - p[k];
                e2[k] = p[6 + k] - p[k];
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            r.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
            big = 0;
            for (int k = 0; k < 3; k++)
            begin
                mg = (cr[k] < 0) ? -cr[k] : cr[k];
                if (mg > big)
                    big = mg;
            end
            sh = 0;
            while (sh < 63 && (big >> sh) >= (64'd1 << 30))
                sh++;
            for (int k = 0; k < 3; k++)
            begin
                mg = (cr[k] < 0) ? -cr[k] : cr[k];
                mg = mg >> sh;
                nv[k] = (cr[k] < 0) ? -longint'(mg) : longint'(mg);
            end
            if (r.degen)
            begin
                nv = '{0, 0, 0};
                degen_seen++;
            end
            else
            begin
                to_unit(nv, nv);
            end
            mg = (nv[0] < 0) ? -nv[0] : nv[0];
            if (mg > longint'(threshold))
            begin
                d = nv[1];
                tq[0] = -nv[0] * d;
                tq[1] = 64'sd268435456 - nv[1] * d;
                tq[2] = -nv[2] * d;
                yseed_seen++;
            end
            else
            begin
                d = nv[0];
                tq[0] = 64'sd268435456 - nv[0] * d;
                tq[1] = -nv[1] * d;
                tq[2] = -nv[2] * d;
            end
            to_unit(tq, tv);
            for (int k = 0; k < 3; k++)
            begin
                r.idx[k] = w.idx[k];
                r.nrm[k] = nv[k][CompW-1:0];
                r.tan[k] = tv[k][CompW-1:0];
            end
            pending = {pending, r};
        endfunction

        task report(string what, logic [IdxW-1:0] got, logic [IdxW-1:0] want);
            errors++;
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        endtask

        task check(face_word_t a);
            face_word_t e;
            if (pending.size() == 0)
            begin
                report("unexpected output word", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            for (int k = 0; k < 3; k++)
            begin
                if (a.idx[k] !== e.idx[k])
                    report($sformatf("index %0d", k), a.idx[k], e.idx[k]);
                if (a.nrm[k] !== e.nrm[k])
                    report($sformatf("normal %0d", k), a.nrm[k], e.nrm[k]);
                if (a.tan[k] !== e.tan[k])
                    report($sformatf("tangent %0d", k), a.tan[k], e.tan[k]);
            end
            if (a.degen !== e.degen)
                report("degenerate", a.degen, e.degen);
        endtask
    endclass

    logic                     clk = 0;
    logic                     rst_n = 0;
    logic                     in_valid = 0;
    logic                     in_stall;
    logic [IdxW-1:0]          index_a = 0, index_b = 0, index_c = 0;
    logic signed [CoordW-1:0] a_x = 0, a_y = 0, a_z = 0;
    logic signed [CoordW-1:0] b_x = 0, b_y = 0, b_z = 0;
    logic signed [CoordW-1:0] c_x = 0, c_y = 0, c_z = 0;
    logic                     out_valid;
    logic                     out_stall = 0;
    logic [IdxW-1:0]          out_index_a, out_index_b, out_index_c;
    logic signed [CompW-1:0]  normal_x, normal_y, normal_z;
    logic signed [CompW-1:0]  tangent_x, tangent_y, tangent_z;
    logic                     degenerate;
    logic                     cfg_valid = 0;
    logic                     cfg_ready;
    logic [ThrW-1:0]          cfg_data = 0;

    int idle_pct  = 0;
    int stall_pct = 0;

    face_scoreboard sb = new();

    triangle_face_normal_tangent dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index_a(out_index_a),
        .out_index_b(out_index_b),
        .out_index_c(out_index_c),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .tangent_x  (tangent_x),
        .tangent_y  (tangent_y),
        .tangent_z  (tangent_z),
        .degenerate (degenerate),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        tri_word_t  w;
        face_word_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            w.idx = '{index_a, index_b, index_c};
            w.p   = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
            sb.note(w);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r.idx   = '{out_index_a, out_index_b, out_index_c};
            r.nrm   = '{normal_x, normal_y, normal_z};
            r.tan   = '{tangent_x, tangent_y, tangent_z};
            r.degen = degenerate;
            sb.check(r);
        end
    end

    task send(tri_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        index_a  <= w.idx[0];
        index_b  <= w.idx[1];
        index_c  <= w.idx[2];
        a_x      <= w.p[0];
        a_y      <= w.p[1];
        a_z      <= w.p[2];
        b_x      <= w.p[3];
        b_y      <= w.p[4];
        b_z      <= w.p[5];
        c_x      <= w.p[6];
        c_y      <= w.p[7];
        c_z      <= w.p[8];
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task write_threshold(logic [ThrW-1:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.threshold = v;
    endtask

    function tri_word_t make_tri(logic [IdxW-1:0] ia, logic [IdxW-1:0] ib,
                                 logic [IdxW-1:0] ic, int q[9]);
        tri_word_t w;
        w.idx = '{ia, ib, ic};
        for (int k = 0; k < 9; k++)
            w.p[k] = CoordW'(q[k]);
        return w;
    endfunction

    function tri_word_t rand_tri();
        tri_word_t w;
        int        q [9];
        int        axis;
        int        base;
        int        mode;
        mode = $urandom_range(9);
        axis = $urandom_range(2);
        for (int k = 0; k < 9; k++)
            q[k] = $urandom;
        if (mode >= 3 && mode <= 5)
        begin
            for (int k = 0; k < 3; k++)
            begin
                base = $urandom;
                for (int c = 0; c < 3; c++)
                    q[3 * c + k] = base + $urandom_range(8191) - 4096;
            end
        end
        if (mode == 6 || mode == 7)
        begin
            base = $urandom;
            for (int c = 0; c < 3; c++)
                q[3 * c + axis] = base + $urandom_range(3) - 1;
        end
        if (mode == 8)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q[k]     = $urandom_range(65535) - 32768;
                q[3 + k] = q[k] + $urandom_range(255) - 128;
                q[6 + k] = q[k] + 2 * (q[3 + k] - q[k]);
            end
        end
        if (mode == 9)
        begin
            for (int k = 0; k < 3; k++)
                q[6 + k] = q[3 * ($urandom_range(1)) + k];
        end
        w = make_tri($urandom, $urandom, $urandom, q);
        return w;
    endfunction

    task directed();
        int one;
        int hi;
        int lo;
        one = 65536;
        hi  = 8388607;
        lo  = -8388608;
        send(make_tri(0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send(make_tri('1, '1, '1, '{5, 6, 7, 5, 6, 7, 5, 6, 7}));
        send(make_tri(1, 2, 3, '{0, 0, 0, 0, one, 0, 0, 0, one}));
        send(make_tri(4, 5, 6, '{0, 0, 0, 0, 0, one, 0, one, 0}));
        send(make_tri(7, 8, 9, '{0, 0, 0, one, 0, 0, 0, one, 0}));
        send(make_tri(10, 11, 12, '{0, 0, 0, 0, 0, one, one, 0, 0}));
        send(make_tri(13, 14, 15, '{0, 0, 0, one, 0, 0, 0, 0, one}));
        send(make_tri('1, 0, '1, '{lo, lo, lo, hi, lo, lo, lo, hi, lo}));
        send(make_tri(0, '1, 0, '{hi, hi, hi, lo, hi, hi, hi, lo, hi}));
        send(make_tri(32'h80000000, 32'h7fffffff, 32'h55555555,
                      '{lo, lo, lo, hi, hi, lo, lo, hi, hi}));
        send(make_tri(16, 17, 18, '{lo, hi, lo, hi, lo, hi, lo, lo, hi}));
        send(make_tri(19, 20, 21, '{0, 0, 0, 1, 0, 0, 0, 1, 0}));
        send(make_tri(22, 23, 24, '{0, 0, 0, one, one, 0, 2 * one, 2 * one, 0}));
        send(make_tri(25, 26, 27, '{0, 0, 0, 0, one, 0, 0, 0, -one}));
        send(make_tri(28, 29, 30, '{0, 0, 0, 0, one, one / 2, 0, 0, one}));
        send(make_tri(31, 32, 33, '{0, 0, 0, one / 8, one, 0, 0, 0, one}));
        send(make_tri(34, 35, 36, '{0, 0, 0, hi, 0, 0, 0, hi, 0}));
    endtask

    initial
    begin
        int idle_set [5]  = '{0, 76, 0, 30, 0};
        int stall_set [5] = '{0, 0, 76, 30, 0};
        logic [ThrW-1:0] thr_set [5];
        thr_set = '{THRESH_RESET, 15'd0, 15'h7fff, 15'd16384, 15'($urandom_range(16384))};
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        directed();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thr_set[ph]);
            directed();
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < 170; n++)
            begin
                if (n == 85)
                    drain();
                send(rand_tri());
            end
            stall_pct = 0;
            idle_pct  = 0;
        end
        drain();
        $display("Checked %0d faces over 5 thresholds and 4 idle/stall mixes,",
                 sb.checked);
        $display("%0d degenerate and %0d seeded from the y axis.",
                 sb.degen_seen, sb.yseed_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
